// ===== src/reserved_word_substituter_top_assert.svh =====
// Assertion macros for the reserved word substituter checker.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef RESERVED_WORD_SUBSTITUTER_TOP_ASSERT_SVH
`define RESERVED_WORD_SUBSTITUTER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define RWS_AST_IMP(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("rwsub check failed");

// Next-cycle implication, checked out of reset
`define RWS_AST_NXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("rwsub check failed");

`endif

// ===== src/rwsub_pkg.sv =====
// Shared types, constants and dictionary tables of the word substituter.
// No dependencies.
`default_nettype none
package rwsub_pkg;

    localparam int WIN_DEPTH = 32;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);
    localparam int TXT_MAX   = 30;
    localparam logic [2:0] ACTIVE_WORDS = 3'd5;

    localparam logic [1:0] CFG_DIRECTION = 2'd0;
    localparam logic [1:0] CFG_LIMIT     = 2'd1;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_present;
        logic        finished;
        logic [15:0] total_length;
        logic        overflow;
    } rwsub_res_t;

    typedef struct packed {
        logic push;
        logic flush;
    } rwsub_qctl_t;

    localparam logic [8*TXT_MAX-1:0] W0 = "<HTML>";
    localparam logic [8*TXT_MAX-1:0] E0 = "&#60;&#72;&#84;&#77;&#76;&#62;";
    localparam logic [8*TXT_MAX-1:0] W1 = "<DIV>";
    localparam logic [8*TXT_MAX-1:0] E1 = "&#60;&#68;&#73;&#86;&#62;";
    localparam logic [8*TXT_MAX-1:0] W2 = "SELECT";
    localparam logic [8*TXT_MAX-1:0] E2 = "&#83;&#69;&#76;&#69;&#67;&#84;";
    localparam logic [8*TXT_MAX-1:0] W3 = "INSERT";
    localparam logic [8*TXT_MAX-1:0] E3 = "&#73;&#78;&#83;&#69;&#82;&#84;";
    localparam logic [8*TXT_MAX-1:0] W4 = "CREATE";
    localparam logic [8*TXT_MAX-1:0] E4 = "&#67;&#82;&#69;&#65;&#84;&#69;";

    // column 0 is the word, column 1 the entity text
    function automatic logic [4:0] txt_len(input logic col, input logic [2:0] e);
        logic [4:0] l;
        case (e)
            3'd1:    l = col ? 5'd25 : 5'd5;
            3'd0, 3'd2, 3'd3, 3'd4: l = col ? 5'd30 : 5'd6;
            default: l = 5'd1;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] txt_byte(input logic col, input logic [2:0] e,
                                            input logic [4:0] k);
        logic [8*TXT_MAX-1:0] s;
        logic [4:0] idx;
        case ({col, e})
            4'b0_000: s = W0;
            4'b1_000: s = E0;
            4'b0_001: s = W1;
            4'b1_001: s = E1;
            4'b0_010: s = W2;
            4'b1_010: s = E2;
            4'b0_011: s = W3;
            4'b1_011: s = E3;
            4'b0_100: s = W4;
            4'b1_100: s = E4;
            default:  s = '0;
        endcase
        idx = txt_len(col, e) - 5'd1 - k;
        return s[{idx, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== src/rwsub_outq.sv =====
// Result staging: one held word plus the output register, so run_last can
// be set on the last word of an item. Depends on rwsub_pkg.
`default_nettype none
module rwsub_outq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rwsub_pkg::rwsub_qctl_t ctl,
    input  wire rwsub_pkg::rwsub_res_t  res,
    output logic                    free,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [7:0]              out_byte,
    output logic                    out_present,
    output logic                    run_last,
    output logic                    finished,
    output logic [15:0]             total_length,
    output logic                    overflow
);
    rwsub_pkg::rwsub_res_t hold_reg, out_reg;
    logic hold_v_reg, out_v_reg, last_reg;

    assign free = !out_v_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if ((ctl.push || ctl.flush) && hold_v_reg)
                out_v_reg <= 1'b1;
            else if (!out_stall)
                out_v_reg <= 1'b0;
            if (ctl.push)
                hold_v_reg <= 1'b1;
            else if (ctl.flush)
                hold_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
            hold_reg <= res;
        if ((ctl.push || ctl.flush) && hold_v_reg)
        begin
            out_reg  <= hold_reg;
            last_reg <= ctl.flush;
        end
    end

    assign out_valid    = out_v_reg;
    assign out_byte     = out_reg.out_byte;
    assign out_present  = out_reg.out_present;
    assign run_last     = last_reg;
    assign finished     = out_reg.finished;
    assign total_length = out_reg.total_length;
    assign overflow     = out_reg.overflow;
endmodule
`default_nettype wire

// ===== src/reserved_word_substituter_top.sv =====
// Top level of the reserved word substituter: lookahead window memory,
// match sequencer and limit tracking. Depends on rwsub_pkg, rwsub_outq.
//
//  channel | signals                                     | flow
//  in      | in_valid/in_stall, in_byte, byte_present,   | source -> block
//          | source_end                                  |
//  out     | out_valid/out_stall, out_byte, out_present, | block -> sink
//          | run_last, finished, total_length, overflow  |
//  cfg     | cfg_we, cfg_index, cfg_data                 | host -> block
//
// An input word is taken only in the idle state; in_stall is high while its
// results are worked out. Each table entry tried is compared byte by byte,
// each byte with one window memory read and then one compare, and the entry
// is decided once it runs out of bytes to compare. Each item ends with a
// wrap-up through S_END and S_FLUSH.
// Reset clears control state; the window memory holds no reset value.
// A stall on the output holds the sequencer wherever it wants to emit.
`default_nettype none
module reserved_word_substituter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        byte_present,
    input  wire logic        source_end,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             out_present,
    output logic             run_last,
    output logic             finished,
    output logic [15:0]      total_length,
    output logic             overflow,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHK   = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_HEMIT = 3'd3;
    localparam logic [2:0] S_REPL  = 3'd4;
    localparam logic [2:0] S_END   = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    localparam int AW = rwsub_pkg::WIN_AW;

    logic [2:0]    state_reg, state_next;
    logic [2:0]    e_reg, e_next;
    logic [4:0]    k_reg, k_next;
    logic [AW-1:0] head_reg, head_next;
    logic [5:0]    fill_reg, fill_next;
    logic [15:0]   emitted_reg, emitted_next;
    logic          ovf_reg, ovf_next;
    logic          final_reg, final_next;
    logic          dir_reg;
    logic [15:0]   limit_reg;

    // window memory
    logic [7:0]    win_mem [rwsub_pkg::WIN_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;

    logic                  q_free;
    rwsub_pkg::rwsub_qctl_t q_ctl;
    rwsub_pkg::rwsub_res_t  q_res;

    logic [4:0]  plen, rlen, n_cmp;
    logic        hit_limit;

    assign plen      = rwsub_pkg::txt_len(dir_reg, e_reg);
    assign rlen      = rwsub_pkg::txt_len(!dir_reg, e_reg);
    assign n_cmp     = ({1'b0, plen} < fill_reg) ? plen : fill_reg[4:0];
    assign hit_limit = ({1'b0, emitted_reg} + 17'd1) >= {1'b0, limit_reg};
    assign in_stall  = (state_reg != S_IDLE);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= 1'b0;
            limit_reg <= 16'd128;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rwsub_pkg::CFG_DIRECTION[0])
                dir_reg <= cfg_data[0];
            else
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            win_mem[wr_addr] <= in_byte;
        if (rd_en)
            rd_data_reg <= win_mem[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        e_next       = e_reg;
        k_next       = k_reg;
        head_next    = head_reg;
        fill_next    = fill_reg;
        emitted_next = emitted_reg;
        ovf_next     = ovf_reg;
        final_next   = final_reg;
        wr_en        = 1'b0;
        wr_addr      = head_reg + fill_reg[AW-1:0];
        rd_en        = 1'b0;
        rd_addr      = head_reg + k_reg;
        q_ctl        = '0;
        q_res        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    e_next     = 3'd0;
                    k_next     = 5'd0;
                    final_next = source_end;
                    if (byte_present && !ovf_reg)
                    begin
                        wr_en      = 1'b1;
                        fill_next  = fill_reg + 6'd1;
                        state_next = S_CHK;
                    end
                    else if (source_end)
                        state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (fill_reg == 6'd0 || ovf_reg)
                    state_next = S_END;
                else if (e_reg == rwsub_pkg::ACTIVE_WORDS)
                begin
                    // no entry wins: copy the head byte
                    rd_en      = 1'b1;
                    rd_addr    = head_reg;
                    state_next = S_HEMIT;
                end
                else if (k_reg < n_cmp)
                begin
                    rd_en      = 1'b1;
                    state_next = S_CMP;
                end
                else if ({1'b0, plen} <= fill_reg)
                begin
                    k_next     = 5'd0;
                    state_next = S_REPL;
                end
                else if (final_reg)
                begin
                    e_next = e_reg + 3'd1;
                    k_next = 5'd0;
                end
                else
                    state_next = S_END;   // wait for more bytes
            end
            S_CMP:
            begin
                state_next = S_CHK;
                if (rd_data_reg == rwsub_pkg::txt_byte(dir_reg, e_reg, k_reg))
                    k_next = k_reg + 5'd1;
                else
                begin
                    e_next = e_reg + 3'd1;
                    k_next = 5'd0;
                end
            end
            S_HEMIT:
            begin
                if (q_free)
                begin
                    e_next = 3'd0;
                    k_next = 5'd0;
                    if (hit_limit)
                    begin
                        ovf_next   = 1'b1;
                        fill_next  = 6'd0;
                        state_next = S_END;
                    end
                    else
                    begin
                        q_ctl.push        = 1'b1;
                        q_res.out_byte    = rd_data_reg;
                        q_res.out_present = 1'b1;
                        emitted_next      = emitted_reg + 16'd1;
                        head_next         = head_reg + {{(AW-1){1'b0}}, 1'b1};
                        fill_next         = fill_reg - 6'd1;
                        state_next        = S_CHK;
                    end
                end
            end
            S_REPL:
            begin
                if (q_free)
                begin
                    if (hit_limit)
                    begin
                        ovf_next   = 1'b1;
                        fill_next  = 6'd0;
                        state_next = S_END;
                    end
                    else
                    begin
                        q_ctl.push        = 1'b1;
                        q_res.out_byte    = rwsub_pkg::txt_byte(!dir_reg, e_reg, k_reg);
                        q_res.out_present = 1'b1;
                        emitted_next      = emitted_reg + 16'd1;
                        k_next            = k_reg + 5'd1;
                        if (k_reg + 5'd1 == rlen)
                        begin
                            head_next  = head_reg + plen[AW-1:0];
                            fill_next  = fill_reg - {1'b0, plen};
                            e_next     = 3'd0;
                            k_next     = 5'd0;
                            state_next = S_CHK;
                        end
                    end
                end
            end
            S_END:
            begin
                if (!final_reg)
                    state_next = S_FLUSH;
                else if (q_free)
                begin
                    q_ctl.push     = 1'b1;
                    q_res.finished = 1'b1;
                    q_res.overflow = ovf_reg || (limit_reg == 16'd0);
                    q_res.total_length = q_res.overflow ? 16'd0 : emitted_reg;
                    fill_next      = 6'd0;
                    head_next      = '0;
                    emitted_next   = 16'd0;
                    ovf_next       = 1'b0;
                    state_next     = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (q_free)
                begin
                    q_ctl.flush = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            e_reg       <= 3'd0;
            k_reg       <= 5'd0;
            head_reg    <= '0;
            fill_reg    <= 6'd0;
            emitted_reg <= 16'd0;
            ovf_reg     <= 1'b0;
            final_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            e_reg       <= e_next;
            k_reg       <= k_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            emitted_reg <= emitted_next;
            ovf_reg     <= ovf_next;
            final_reg   <= final_next;
        end
    end

    rwsub_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (q_ctl),
        .res          (q_res),
        .free         (q_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .out_present  (out_present),
        .run_last     (run_last),
        .finished     (finished),
        .total_length (total_length),
        .overflow     (overflow)
    );
endmodule
`default_nettype wire

// ===== src/rwsub_checker.sv =====
// Port-level checks for the reserved word substituter, bound to the top.
// Depends on reserved_word_substituter_top_assert.svh.
`default_nettype none
`include "reserved_word_substituter_top_assert.svh"
module rwsub_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        out_present,
    input wire logic        run_last,
    input wire logic        finished,
    input wire logic        overflow,
    input wire logic [15:0] total_length
);
    `RWS_AST_IMP(a_byte_not_final, out_valid && out_present, !finished)
    `RWS_AST_IMP(a_final_is_last, out_valid && finished, run_last)
    `RWS_AST_IMP(a_ovf_zero_len, out_valid && overflow, finished && total_length == 16'd0)
    `RWS_AST_NXT(a_hold_valid, out_valid && out_stall, out_valid)
endmodule

bind reserved_word_substituter_top rwsub_checker u_rwsub_checker (.*);
`default_nettype wire

// ===== tb/tb_reserved_word_substituter_top.sv =====
// Self-checking testbench for reserved_word_substituter_top: random and directed
// source strings, checked against a dictionary substitution predictor.
// Depends on rwsub_pkg and the block's RTL only.
`timescale 1ns / 1ps
`default_nettype none
module tb_reserved_word_substituter_top;

    localparam int WINDOW_BYTES = rwsub_pkg::WIN_DEPTH;
    localparam int RUN_LIMIT    = 1000000;
    localparam int SETTLE       = 400;

    // one source word as driven on the input channel
    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last_of_string;
    } src_word_t;

    // one destination word as it should leave the block
    typedef struct {
        logic [7:0]  data;
        logic        present;
        logic        run_last;
        logic        finished;
        logic [15:0] length;
        logic        overflow;
    } dst_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        byte_present = 1'b0;
    logic        source_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        out_present;
    logic        run_last;
    logic        finished;
    logic [15:0] total_length;
    logic        overflow;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    reserved_word_substituter_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
        .byte_present(byte_present), .source_end(source_end),
        .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
        .out_present(out_present), .run_last(run_last), .finished(finished),
        .total_length(total_length), .overflow(overflow),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // Dictionary: column 0 holds the words, column 1 the entity text.
    string dict_text [2][5] = '{
        '{"<HTML>", "<DIV>", "SELECT", "INSERT", "CREATE"},
        '{"&#60;&#72;&#84;&#77;&#76;&#62;", "&#60;&#68;&#73;&#86;&#62;",
          "&#83;&#69;&#76;&#69;&#67;&#84;", "&#73;&#78;&#83;&#69;&#82;&#84;",
          "&#67;&#82;&#69;&#65;&#84;&#69;"}
    };

    // Predictor state: its own copy of the registers and the lookahead window
    logic        swap_cols;
    logic [15:0] dest_limit;
    logic [7:0]  window [WINDOW_BYTES];
    int          window_fill;
    int          written;
    bit          over_limit;

    src_word_t pending_src[$];
    dst_word_t expected_out[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  errors;
    int  cycles;
    int  words_sent;
    int  words_seen;
    int  strings_done;
    int  overflow_strings;

    // Append one destination byte unless the capacity is spent
    function automatic void put_dest_byte(input logic [7:0] b);
        dst_word_t w;
        if (over_limit)
            return;
        if (written + 1 >= int'(dest_limit)) begin
            over_limit = 1'b1;
            return;
        end
        w = '{b, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0};
        expected_out.push_back(w);
        written++;
    endfunction

    // -2: wait for more bytes, -1: copy the head byte, else winning entry
    function automatic int pick_entry(input bit at_end);
        string pat;
        int    plen;
        int    n;
        bit    same;
        for (int e = 0; e < 5; e++) begin
            pat  = dict_text[swap_cols][e];
            plen = pat.len();
            n    = plen < window_fill ? plen : window_fill;
            same = 1'b1;
            for (int k = 0; k < n; k++)
                if (window[k] != pat[k])
                    same = 1'b0;
            if (!same)
                continue;
            if (plen <= window_fill)
                return e;
            if (at_end || window_fill >= WINDOW_BYTES)
                continue;
            return -2;
        end
        return -1;
    endfunction

    function automatic void drop_head(input int n);
        if (n >= window_fill) begin
            window_fill = 0;
            return;
        end
        for (int k = 0; k < window_fill - n; k++)
            window[k] = window[k + n];
        window_fill -= n;
    endfunction

    function automatic void resolve_window(input bit at_end);
        int    r;
        string rep;
        while (window_fill > 0 && !over_limit) begin
            r = pick_entry(at_end);
            if (r == -2)
                break;
            if (r >= 0) begin
                rep = dict_text[!swap_cols][r];
                for (int k = 0; k < rep.len() && !over_limit; k++)
                    put_dest_byte(rep[k]);
                drop_head(dict_text[swap_cols][r].len());
            end else begin
                put_dest_byte(window[0]);
                drop_head(1);
            end
        end
        if (over_limit)
            window_fill = 0;
    endfunction

    // Work out every destination word that one accepted source word causes
    function automatic void substitute_word(input logic [7:0] b, input logic p,
                                            input logic e);
        int        before_cnt;
        dst_word_t w;
        before_cnt = expected_out.size();
        if (p && !over_limit) begin
            if (window_fill < WINDOW_BYTES)
                window[window_fill++] = b;
            resolve_window(e);
        end else if (e) begin
            resolve_window(1'b1);
        end
        if (e) begin
            if (dest_limit == 16'd0)
                over_limit = 1'b1;
            w = '{8'd0, 1'b0, 1'b0, 1'b1, over_limit ? 16'd0 : 16'(written),
                  over_limit};
            expected_out.push_back(w);
            strings_done++;
            if (over_limit)
                overflow_strings++;
            window_fill = 0;
            written     = 0;
            over_limit  = 1'b0;
        end
        if (expected_out.size() > before_cnt)
            expected_out[expected_out.size() - 1].run_last = 1'b1;
    endfunction

    // Driver: present the next pending word, hold it while stalled
    always @(posedge clk or negedge rst_n) begin
        src_word_t nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                substitute_word(in_byte, byte_present, source_end);
                words_sent++;
            end
            if (!in_valid || !in_stall) begin
                if (pending_src.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_src.pop_front();
                    in_valid     <= 1'b1;
                    in_byte      <= nxt.data;
                    byte_present <= nxt.present;
                    source_end   <= nxt.last_of_string;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, compare each accepted word in order
    always @(posedge clk or negedge rst_n) begin
        dst_word_t w;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                words_seen++;
                if (expected_out.size() == 0) begin
                    $error("unexpected output word: out_byte=%0h finished=%0b",
                           out_byte, finished);
                    errors++;
                end else begin
                    w = expected_out.pop_front();
                    if (out_byte !== w.data) begin
                        $error("out_byte: expected %0h, got %0h", w.data, out_byte);
                        errors++;
                    end
                    if (out_present !== w.present) begin
                        $error("out_present: expected %0b, got %0b", w.present, out_present);
                        errors++;
                    end
                    if (run_last !== w.run_last) begin
                        $error("run_last: expected %0b, got %0b", w.run_last, run_last);
                        errors++;
                    end
                    if (finished !== w.finished) begin
                        $error("finished: expected %0b, got %0b", w.finished, finished);
                        errors++;
                    end
                    if (total_length !== w.length) begin
                        $error("total_length: expected %0d, got %0d", w.length, total_length);
                        errors++;
                    end
                    if (overflow !== w.overflow) begin
                        $error("overflow: expected %0b, got %0b", w.overflow, overflow);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog on total run length
    always @(posedge clk) begin
        cycles++;
        if (cycles > RUN_LIMIT) begin
            $display("** reserved_word_substituter_top: FAILED **");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic p, input logic e);
        src_word_t s;
        s = '{b, p, e};
        pending_src.push_back(s);
    endtask

    // Queue a text; close marks its last byte as the end of the string
    task automatic queue_text(input string t, input bit close);
        for (int k = 0; k < t.len(); k++)
            queue_byte(t[k], 1'b1, close && (k == t.len() - 1));
    endtask

    // Registers change only here, with the block idle; keep the predictor in step
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx[0:0];
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == rwsub_pkg::CFG_DIRECTION)
            swap_cols = val[0];
        else
            dest_limit = val;
    endtask

    // Wait for all queued words to go in and all results to come out
    task automatic drain_all();
        wait (pending_src.size() == 0 && !in_valid && expected_out.size() == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Well-formed strings with random content, plus some noise
    task automatic queue_random_strings(input int budget);
        int    start;
        int    e;
        int    cut;
        string pat;
        start = pending_src.size();
        while (pending_src.size() - start < budget) begin
            repeat ($urandom_range(1, 4)) begin
                e   = $urandom_range(4);
                pat = dict_text[swap_cols][e];
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: queue_text(pat, 1'b0);
                    6: begin
                        // broken word: a prefix only
                        cut = $urandom_range(1, pat.len() - 1);
                        queue_text(pat.substr(0, cut - 1), 1'b0);
                    end
                    7, 8: queue_byte(8'($urandom_range(255)), 1'b1, 1'b0);
                    default: queue_byte(8'($urandom_range(255)), 1'b0, 1'b0);
                endcase
            end
            // close the string, sometimes with a last byte riding along
            queue_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end
    endtask

    initial begin
        swap_cols   = 1'b0;
        dest_limit  = 16'd128;
        window_fill = 0;
        written     = 0;
        over_limit  = 1'b0;
        errors = 0; cycles = 0; words_sent = 0; words_seen = 0;
        strings_done = 0; overflow_strings = 0;
        send_idle_pct = 26;
        recv_idle_pct = 50;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: matches, a word cut short by the end, empty string,
        // a word carrying nothing, byte extremes
        write_reg(rwsub_pkg::CFG_DIRECTION, 16'd0);
        write_reg(rwsub_pkg::CFG_LIMIT, 16'd128);
        queue_text("<HTML>", 1'b1);
        queue_text("SELEC", 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hA5, 1'b0, 1'b0);
        queue_byte(8'h00, 1'b1, 1'b0);
        queue_byte(8'hFF, 1'b1, 1'b1);
        drain_all();
        // Limit of zero fails even on an empty string
        write_reg(rwsub_pkg::CFG_LIMIT, 16'd0);
        queue_byte(8'h00, 1'b0, 1'b1);
        drain_all();
        // Limit of one: no byte fits
        write_reg(rwsub_pkg::CFG_LIMIT, 16'd1);
        queue_byte("A", 1'b1, 1'b1);
        drain_all();
        // Overflow in the middle of an expansion
        write_reg(rwsub_pkg::CFG_LIMIT, 16'd8);
        queue_text("<DIV>", 1'b1);
        drain_all();

        // Random: sender idles less than the receiver, widest limit
        write_reg(rwsub_pkg::CFG_LIMIT, 16'hFFFF);
        queue_random_strings(50);
        drain_all();
        // Reverse direction, other idle mix, tight random limit
        send_idle_pct = 50;
        recv_idle_pct = 26;
        write_reg(rwsub_pkg::CFG_DIRECTION, 16'd1);
        write_reg(rwsub_pkg::CFG_LIMIT, 16'($urandom_range(20, 200)));
        queue_random_strings(60);
        drain_all();
        // No idling, random settings
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(rwsub_pkg::CFG_DIRECTION, 16'($urandom_range(1)));
        write_reg(rwsub_pkg::CFG_LIMIT, 16'($urandom_range(4, 128)));
        queue_random_strings(40);
        drain_all();

        $display("Covered %0d input words and %0d output words over %0d strings,",
                 words_sent, words_seen, strings_done);
        $display("%0d of them ended in overflow; both directions, limits 0 to 65535.",
                 overflow_strings);
        if (errors == 0)
            $display("** reserved_word_substituter_top: PASSED **");
        else
            $display("** reserved_word_substituter_top: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/rwsub_pkg.sv
src/rwsub_outq.sv
src/reserved_word_substituter_top.sv
src/rwsub_checker.sv
tb/tb_reserved_word_substituter_top.sv
